// File: hdl/kmeans_1d_clustering_defines.svh
// assertion macros for the 1-d k-means block
// used by the top level; expects signals named clock and reset in scope
`ifndef KMEANS_1D_CLUSTERING_DEFINES_SVH
`define KMEANS_1D_CLUSTERING_DEFINES_SVH

// same-cycle implication
`define KM1D_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define KM1D_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/km1d_pkg.sv
// shared types and constants for the 1-d k-means block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package km1d_pkg;

   localparam int DEF_MAX_POINTS   = 4096;
   localparam int DEF_MAX_CLUSTERS = 16;

   localparam int ACTION_W   = 3;
   localparam int POS_W      = 12;
   localparam int VALUE_W    = 32;
   localparam int KIND_W     = 2;
   localparam int ITER_W     = 10;
   localparam int ERR_W      = 64;
   localparam int CLUSTER_W  = 4;
   localparam int NPTS_W     = 13;
   localparam int NCLU_W     = 5;
   localparam int FRAC_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 112;

   // rsp_tdata field offsets
   localparam int OFS_ITER     = 0;
   localparam int OFS_ERR      = OFS_ITER + ITER_W;
   localparam int OFS_MONO     = OFS_ERR + ERR_W;
   localparam int OFS_CLUSTER  = OFS_MONO + 1;
   localparam int OFS_CENTROID = OFS_CLUSTER + CLUSTER_W;

   localparam logic [NPTS_W-1:0] RST_NUM_POINTS   = 13'd1;
   localparam logic [NCLU_W-1:0] RST_NUM_CLUSTERS = 5'd1;
   localparam logic [ITER_W-1:0] RST_MAX_ITER     = 10'd50;
   localparam logic [FRAC_W-1:0] RST_FRACTION     = 32'd429497;
   localparam logic [ERR_W-1:0]  MONO_TOL         = 64'd4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_POINT    = 3'd0,
      ACT_LOAD_CENTROID = 3'd1,
      ACT_RUN           = 3'd2,
      ACT_READ_ASSIGN   = 3'd3,
      ACT_READ_CENTROID = 3'd4
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RUN      = 2'd0,
      KIND_ASSIGN   = 2'd1,
      KIND_CENTROID = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_POINTS   = 2'd0,
      CSR_NUM_CLUSTERS = 2'd1,
      CSR_MAX_ITER     = 2'd2,
      CSR_FRACTION     = 2'd3
   } csr_index_type;

   typedef enum logic [16:0] {
      S_IDLE    = 17'h00001,
      S_RD      = 17'h00002,
      S_OUT     = 17'h00004,
      S_RUN_CHK = 17'h00008,
      S_A_ADDR  = 17'h00010,
      S_A_MUL   = 17'h00020,
      S_A_CMP   = 17'h00040,
      S_A_ACC   = 17'h00080,
      S_A_MONO  = 17'h00100,
      S_CV0     = 17'h00200,
      S_CV1     = 17'h00400,
      S_CV2     = 17'h00800,
      S_CV3     = 17'h01000,
      S_U_ADDR  = 17'h02000,
      S_U_ACC   = 17'h04000,
      S_D_LOAD  = 17'h08000,
      S_D_DIV   = 17'h10000
   } state_type;

   typedef struct packed {
      logic ld_pt;
      logic ld_cen;
      logic cap_rd;
      logic run_init;
      logic a_start;
      logic c_clear;
      logic mul;
      logic cmp;
      logic c_inc;
      logic a_acc;
      logic i_inc;
      logic mono;
      logic cv0;
      logic cv1;
      logic cv2;
      logic u_start;
      logic u_acc;
      logic d_fill;
      logic div_start;
      logic d_wr;
      logic prev_upd;
      logic use_pos;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic i_last;
      logic c_last;
      logic it_lt_max;
      logic converged;
      logic cnt_zero;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: hdl/km1d_ctrl.sv
// controller state machine for the 1-d k-means block
// depends on km1d_pkg; drives datapath commands from datapath status
`timescale 1ns / 1ps
module km1d_ctrl import km1d_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_tready,
   output cmd_type             cmd,
   input  status_type          sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (action_type'(req_action))
                  ACT_LOAD_POINT:    cmd.ld_pt = 1'b1;
                  ACT_LOAD_CENTROID: cmd.ld_cen = 1'b1;
                  ACT_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = S_RUN_CHK;
                  end
                  ACT_READ_ASSIGN, ACT_READ_CENTROID: begin
                     cmd.cap_rd = 1'b1;
                     state_in   = S_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD: begin
            cmd.use_pos = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            cmd.use_pos = 1'b1;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RUN_CHK: begin
            if (sts.it_lt_max) begin
               cmd.a_start = 1'b1;
               state_in    = S_A_ADDR;
            end else begin
               state_in = S_OUT;
            end
         end
         S_A_ADDR: begin
            cmd.c_clear = 1'b1;
            state_in    = S_A_MUL;
         end
         S_A_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_A_CMP;
         end
         S_A_CMP: begin
            cmd.cmp   = 1'b1;
            cmd.c_inc = 1'b1;
            state_in  = sts.c_last ? S_A_ACC : S_A_MUL;
         end
         S_A_ACC: begin
            cmd.a_acc = 1'b1;
            cmd.i_inc = 1'b1;
            state_in  = sts.i_last ? S_A_MONO : S_A_ADDR;
         end
         S_A_MONO: begin
            cmd.mono = 1'b1;
            state_in = S_CV0;
         end
         S_CV0: begin
            cmd.cv0  = 1'b1;
            state_in = S_CV1;
         end
         S_CV1: begin
            cmd.cv1  = 1'b1;
            state_in = S_CV2;
         end
         S_CV2: begin
            cmd.cv2  = 1'b1;
            state_in = S_CV3;
         end
         S_CV3: begin
            if (sts.converged) begin
               state_in = S_OUT;
            end else begin
               cmd.u_start = 1'b1;
               state_in    = S_U_ADDR;
            end
         end
         S_U_ADDR: state_in = S_U_ACC;
         S_U_ACC: begin
            cmd.u_acc = 1'b1;
            cmd.i_inc = 1'b1;
            if (sts.i_last) begin
               cmd.c_clear = 1'b1;
               state_in    = S_D_LOAD;
            end else begin
               state_in = S_U_ADDR;
            end
         end
         S_D_LOAD: begin
            if (sts.cnt_zero) begin
               cmd.d_fill = 1'b1;
               cmd.c_inc  = 1'b1;
               if (sts.c_last) begin
                  cmd.prev_upd = 1'b1;
                  state_in     = S_RUN_CHK;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_D_DIV;
            end
         end
         S_D_DIV: begin
            if (sts.div_done) begin
               cmd.d_wr  = 1'b1;
               cmd.c_inc = 1'b1;
               if (sts.c_last) begin
                  cmd.prev_upd = 1'b1;
                  state_in     = S_RUN_CHK;
               end else begin
                  state_in = S_D_LOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: hdl/km1d_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on km1d_pkg; used by the datapath for centroid means
`timescale 1ns / 1ps
module km1d_div import km1d_pkg::*; #(
   parameter int SW = VALUE_W + 12,
   parameter int DW = NPTS_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] quotient
);

   localparam int CNT_W = $clog2(SW + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SW-1:0]    q_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    div_ff;
   logic [DW:0]      rem_sh;
   logic [DW:0]      rem_in;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, q_ff[SW-1]};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = ge ? rem_sh - {1'b0, div_ff} : rem_sh;
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
         cnt_ff <= CNT_W'(SW);
      end else if (busy_ff && cnt_ff != '0) begin
         rem_ff <= rem_in[DW-1:0];
         q_ff   <= {q_ff[SW-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// File: hdl/km1d_dp.sv
// datapath for the 1-d k-means block: stores, distance unit, sums, result register
// depends on km1d_pkg and km1d_div; steered by km1d_ctrl commands
`timescale 1ns / 1ps
module km1d_dp import km1d_pkg::*; #(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [POS_W-1:0]      req_pos,
   input  logic [VALUE_W-1:0]    req_value,
   input  cmd_type               cmd,
   output status_type            sts,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [KIND_W-1:0]     rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int KW = $clog2(MAX_CLUSTERS + 1);
   localparam int SW = VALUE_W + PW;

   logic [NPTS_W-1:0] npts_ff;
   logic [NCLU_W-1:0] nclu_ff;
   logic [ITER_W-1:0] maxit_ff;
   logic [FRAC_W-1:0] frac_ff;

   logic [VALUE_W-1:0]   pnt_mem [MAX_POINTS];
   logic [CLUSTER_W-1:0] asg_mem [MAX_POINTS];
   logic [VALUE_W-1:0]   pnt_rd_ff;
   logic [CLUSTER_W-1:0] asg_rd_ff;

   logic [VALUE_W-1:0] cent_ff [MAX_CLUSTERS];
   logic [SW-1:0]      sum_ff  [MAX_CLUSTERS];
   logic [NW-1:0]      cnt_ff  [MAX_CLUSTERS];

   logic [POS_W-1:0]  pos_ff;
   kind_type          kind_ff;
   logic [PW-1:0]     i_ff;
   logic [CW-1:0]     c_ff;
   logic [ITER_W-1:0] it_ff;
   logic [ERR_W-1:0]  err_ff;
   logic [ERR_W-1:0]  prev_ff;
   logic              mono_ff;
   logic [NW-1:0]     fill_ff;
   logic [CW-1:0]     best_ff;
   logic [ERR_W-1:0]  bestd_ff;
   logic [ERR_W-1:0]  dist_ff;
   logic [ERR_W-1:0]  pp0_ff;
   logic [ERR_W-1:0]  pp1_ff;
   logic [ERR_W-1:0]  hi_ff;
   logic              lonz_ff;
   logic [ERR_W-1:0]  diff_ff;
   logic [VALUE_W-1:0] pt0_ff;
   logic              neg_ff;

   logic                  rsp_valid_ff;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [NW-1:0]      n_val;
   logic [KW-1:0]      k_val;
   logic [PW-1:0]      mem_addr;
   logic [CW-1:0]      cidx;
   logic [CW-1:0]      sidx;
   logic [VALUE_W-1:0] cent_rd;
   logic [SW-1:0]      sum_rd;
   logic [NW-1:0]      cnt_rd;
   logic [VALUE_W:0]   dx;
   logic [VALUE_W:0]   mag;
   logic [2*VALUE_W+1:0] prod;
   logic [ERR_W:0]     err_sum;
   logic [ERR_W-1:0]   den;
   logic [ERR_W-1:0]   adiff;
   logic [SW-1:0]      sum_mag;
   logic [SW-1:0]      quot;
   logic [SW-1:0]      quot_s;
   logic [SW-1:0]      x_ext;
   logic               div_done;

   // sizes in use
   always_comb begin
      if (npts_ff == '0) begin
         n_val = NW'(1);
      end else if (32'(npts_ff) > 32'(MAX_POINTS)) begin
         n_val = NW'(MAX_POINTS);
      end else begin
         n_val = NW'(npts_ff);
      end
      if (nclu_ff == '0) begin
         k_val = KW'(1);
      end else if (32'(nclu_ff) > 32'(MAX_CLUSTERS)) begin
         k_val = KW'(MAX_CLUSTERS);
      end else begin
         k_val = KW'(nclu_ff);
      end
   end

   always_comb begin
      mem_addr = cmd.use_pos ? PW'(pos_ff) : i_ff;
      cidx     = cmd.use_pos ? CW'(pos_ff) : c_ff;
      sidx     = cmd.u_acc ? CW'(asg_rd_ff) : c_ff;
      cent_rd  = cent_ff[cidx];
      sum_rd   = sum_ff[sidx];
      cnt_rd   = cnt_ff[sidx];
      dx       = {pnt_rd_ff[VALUE_W-1], pnt_rd_ff} - {cent_rd[VALUE_W-1], cent_rd};
      mag      = dx[VALUE_W] ? (~dx + 1'b1) : dx;
      prod     = mag * mag;
      err_sum  = {1'b0, err_ff} + {1'b0, bestd_ff};
      den      = (prev_ff == '0) ? ERR_W'(1) : prev_ff;
      adiff    = (err_ff > prev_ff) ? err_ff - prev_ff : prev_ff - err_ff;
      sum_mag  = sum_rd[SW-1] ? (~sum_rd + 1'b1) : sum_rd;
      quot_s   = neg_ff ? (~quot + 1'b1) : quot;
      x_ext    = {{PW{pnt_rd_ff[VALUE_W-1]}}, pnt_rd_ff};
   end

   km1d_div #(
      .SW (SW),
      .DW (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_mag),
      .divisor  (cnt_rd),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      sts.i_last    = (32'(i_ff) + 32'd1) == 32'(n_val);
      sts.c_last    = (32'(c_ff) + 32'd1) == 32'(k_val);
      sts.it_lt_max = it_ff < maxit_ff;
      sts.converged = (diff_ff < hi_ff) || ((diff_ff == hi_ff) && lonz_ff);
      sts.cnt_zero  = (cnt_rd == '0);
      sts.div_done  = div_done;
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         npts_ff  <= RST_NUM_POINTS;
         nclu_ff  <= RST_NUM_CLUSTERS;
         maxit_ff <= RST_MAX_ITER;
         frac_ff  <= RST_FRACTION;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_POINTS:   npts_ff  <= csr_wdata[NPTS_W-1:0];
            CSR_NUM_CLUSTERS: nclu_ff  <= csr_wdata[NCLU_W-1:0];
            CSR_MAX_ITER:     maxit_ff <= csr_wdata[ITER_W-1:0];
            CSR_FRACTION:     frac_ff  <= csr_wdata[FRAC_W-1:0];
            default:          npts_ff  <= npts_ff;
         endcase
      end
   end

   // point and assignment memories
   always_ff @(posedge clock) begin
      if (cmd.ld_pt && (32'(req_pos) < 32'(MAX_POINTS))) begin
         pnt_mem[PW'(req_pos)] <= req_value;
      end
      pnt_rd_ff <= pnt_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.a_acc) begin
         asg_mem[i_ff] <= CLUSTER_W'(best_ff);
      end
      asg_rd_ff <= asg_mem[mem_addr];
   end

   // entries below the fill count have been written by a run
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.mono && (n_val > fill_ff)) begin
         fill_ff <= n_val;
      end
   end

   // centroids, sums, counts
   always_ff @(posedge clock) begin
      if (cmd.ld_cen && (32'(req_pos) < 32'(MAX_CLUSTERS))) begin
         cent_ff[CW'(req_pos)] <= req_value;
      end else if (cmd.d_fill) begin
         cent_ff[c_ff] <= pt0_ff;
      end else if (cmd.d_wr) begin
         cent_ff[c_ff] <= quot_s[VALUE_W-1:0];
      end
      if (cmd.u_start) begin
         for (int j = 0; j < MAX_CLUSTERS; j++) begin
            sum_ff[j] <= '0;
            cnt_ff[j] <= '0;
         end
      end else if (cmd.u_acc) begin
         sum_ff[sidx] <= sum_rd + x_ext;
         cnt_ff[sidx] <= cnt_rd + 1'b1;
      end
   end

   // run bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.cap_rd) begin
         pos_ff  <= req_pos;
         kind_ff <= (action_type'(req_action) == ACT_READ_ASSIGN) ? KIND_ASSIGN
                                                                  : KIND_CENTROID;
      end
      if (cmd.run_init) begin
         kind_ff <= KIND_RUN;
         prev_ff <= '1;
         mono_ff <= 1'b1;
         it_ff   <= '0;
         err_ff  <= '0;
      end
      if (cmd.a_start || cmd.u_start) begin
         i_ff <= '0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.a_start) begin
         err_ff <= '0;
      end else if (cmd.a_acc) begin
         err_ff <= err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
      end
      if (cmd.c_clear) begin
         c_ff <= '0;
      end else if (cmd.c_inc) begin
         c_ff <= c_ff + 1'b1;
      end
      if (cmd.mul) begin
         dist_ff <= prod[ERR_W-1:0];
      end
      if (cmd.cmp && ((c_ff == '0) || (dist_ff < bestd_ff))) begin
         best_ff  <= c_ff;
         bestd_ff <= dist_ff;
      end
      if (cmd.mono) begin
         it_ff <= it_ff + 1'b1;
         if ((it_ff != '0) && (err_ff > prev_ff) && ((err_ff - prev_ff) > MONO_TOL)) begin
            mono_ff <= 1'b0;
         end
      end
      if (cmd.cv0) begin
         pp0_ff  <= frac_ff * den[31:0];
         diff_ff <= adiff;
      end
      if (cmd.cv1) begin
         pp1_ff <= frac_ff * den[63:32];
      end
      if (cmd.cv2) begin
         hi_ff   <= pp1_ff + {32'd0, pp0_ff[63:32]};
         lonz_ff <= (pp0_ff[31:0] != '0);
      end
      if (cmd.u_acc && (i_ff == '0)) begin
         pt0_ff <= pnt_rd_ff;
      end
      if (cmd.div_start) begin
         neg_ff <= sum_rd[SW-1];
      end
      if (cmd.prev_upd) begin
         prev_ff <= err_ff;
      end
   end

   // result register
   always_comb begin
      rsp_data_in = '0;
      unique case (kind_ff)
         KIND_RUN: begin
            rsp_data_in[OFS_ITER +: ITER_W] = it_ff;
            rsp_data_in[OFS_ERR +: ERR_W]   = err_ff;
            rsp_data_in[OFS_MONO]           = mono_ff;
         end
         KIND_ASSIGN: begin
            if (32'(pos_ff) < 32'(fill_ff)) begin
               rsp_data_in[OFS_CLUSTER +: CLUSTER_W] = asg_rd_ff;
            end
         end
         KIND_CENTROID: begin
            if (32'(pos_ff) < 32'(MAX_CLUSTERS)) begin
               rsp_data_in[OFS_CENTROID +: VALUE_W] = cent_rd;
            end
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/kmeans_1d_clustering.sv
// top level of the 1-d k-means block: controller plus datapath
// depends on km1d_pkg, km1d_ctrl, km1d_dp and kmeans_1d_clustering_defines.svh
//
// usage:
//   req channel carries one action per item: load point, load centroid, run,
//   read assignment, read centroid. loads finish at acceptance and give no result.
//   rsp channel returns one item per run or read, kind in rsp_tuser.
//   csr port writes point count, cluster count, pass limit and convergence
//   fraction; write only while the block is idle.
// sequence: a read passes through S_RD and S_OUT, and rsp_tvalid rises from the
//   result register. a run checks the pass limit before each pass; a pass visits
//   each point for assignment over every cluster, runs the error and convergence
//   checks and, unless converged, visits each point again for sums, then per cluster
//   takes a mean with the iterative divider (SW = 32 + log2(MAX_POINTS)) if not empty.
// throughput: one item at a time; loads are taken back to back, one per cycle.
// reset: configuration returns to its defaults, assignments read as zero until
//   a run writes them, point and centroid stores hold nothing defined.
// stall: a held result keeps its item; loads are still taken, and a run or read
//   waits at its result stage with req_tready low until the held item is taken.
`timescale 1ns / 1ps
`include "kmeans_1d_clustering_defines.svh"
module kmeans_1d_clustering import km1d_pkg::*; #(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position[11:0], value[43:12], zero pad
   input  logic [ACTION_W-1:0]   req_tuser,  // action[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // iterations[9:0], total_error[73:10], monotonic[74], cluster[78:75],
   // centroid[110:79], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,  // result_kind[1:0]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   km1d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   km1d_dp #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_action (req_tuser),
      .req_pos    (req_tdata[POS_W-1:0]),
      .req_value  (req_tdata[POS_W +: VALUE_W]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   `KM1D_ASSERT_SAME(a_out_free, cmd.out_load, sts.out_free, "result loaded over a held item")
   `KM1D_ASSERT_SAME(a_div_nonzero, cmd.div_start, !sts.cnt_zero, "divide by empty cluster")
   `KM1D_ASSERT_NEXT(a_run_busy, req_tvalid && req_tready && (req_tuser == ACT_RUN), !req_tready, "ready during run")

endmodule

// File: tb/kmeans_1d_clustering_test.sv
// self-checking testbench for the 1-d k-means block: loads, runs, reads, csr sweeps
// scoreboard class predicts each result from accepted items; depends on km1d_pkg
// and the kmeans_1d_clustering top level
`timescale 1ns / 1ps
module kmeans_1d_clustering_test;
   import km1d_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int ITEM_TARGET  = 1450;
   localparam int SETTLE       = 20;
   localparam logic [ACTION_W-1:0] ACT_LAST = '1;

   class kmeans_scoreboard;
      typedef struct packed {
         kind_type          kind;
         logic [ITER_W-1:0] iters;
         logic [ERR_W-1:0]  err;
         logic              mono;
         logic [CLUSTER_W-1:0] clu;
         logic [VALUE_W-1:0]   cen;
      } result_type;

      logic [VALUE_W-1:0]   points [DEF_MAX_POINTS];
      logic [VALUE_W-1:0]   centers[DEF_MAX_CLUSTERS];
      logic [CLUSTER_W-1:0] labels [DEF_MAX_POINTS];
      logic [NPTS_W-1:0] n_cfg    = RST_NUM_POINTS;
      logic [NCLU_W-1:0] k_cfg    = RST_NUM_CLUSTERS;
      logic [ITER_W-1:0] iter_cfg = RST_MAX_ITER;
      logic [FRAC_W-1:0] frac_cfg = RST_FRACTION;
      result_type results_due[$];
      int errors = 0;

      function new();
         foreach (points[i]) points[i] = '0;
         foreach (centers[i]) centers[i] = '0;
         foreach (labels[i]) labels[i] = '0;
      endfunction

      function int clamp_size(int v, int mx);
         if (v == 0) return 1;
         return v > mx ? mx : v;
      endfunction

      function logic [ERR_W-1:0] assign_points(int n, int k);
         logic [ERR_W-1:0] total, d, bestd, mag;
         longint diff;
         int best;
         total = '0;
         for (int i = 0; i < n; i++) begin
            best = 0;
            bestd = '0;
            for (int c = 0; c < k; c++) begin
               diff = longint'(signed'(points[i])) - longint'(signed'(centers[c]));
               mag = diff < 0 ? -diff : diff;
               d = mag * mag;
               if (c == 0 || d < bestd) begin
                  bestd = d;
                  best = c;
               end
            end
            labels[i] = CLUSTER_W'(best);
            total = (total > ~bestd) ? '1 : total + bestd;
         end
         return total;
      endfunction

      function void update_centers(int n, int k);
         longint sums[DEF_MAX_CLUSTERS];
         int cnt[DEF_MAX_CLUSTERS];
         foreach (sums[c]) begin
            sums[c] = 0;
            cnt[c] = 0;
         end
         for (int i = 0; i < n; i++) begin
            sums[labels[i]] += longint'(signed'(points[i]));
            cnt[labels[i]]++;
         end
         for (int c = 0; c < k; c++)
            centers[c] = cnt[c] > 0 ? 32'(sums[c] / longint'(cnt[c])) : points[0];
      endfunction

      function bit settled(logic [ERR_W-1:0] cur, logic [ERR_W-1:0] prev);
         logic [127:0] lhs, rhs;
         lhs = {64'd0, cur > prev ? cur - prev : prev - cur} << 32;
         rhs = 128'(frac_cfg) * 128'(prev == 0 ? 64'd1 : prev);
         return lhs < rhs;
      endfunction

      function void note(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                         logic [VALUE_W-1:0] val);
         result_type r;
         logic [ERR_W-1:0] prev;
         int n, k;
         r = '0;
         case (act)
            ACT_LOAD_POINT: points[pos] = val;
            ACT_LOAD_CENTROID: if (pos < DEF_MAX_CLUSTERS) centers[pos] = val;
            ACT_RUN: begin
               n = clamp_size(n_cfg, DEF_MAX_POINTS);
               k = clamp_size(k_cfg, DEF_MAX_CLUSTERS);
               prev = '1;
               r.kind = KIND_RUN;
               r.mono = 1'b1;
               while (r.iters < iter_cfg) begin
                  r.err = assign_points(n, k);
                  if (r.iters > 0 && r.err > prev && r.err - prev > MONO_TOL) r.mono = 1'b0;
                  r.iters++;
                  if (settled(r.err, prev)) break;
                  update_centers(n, k);
                  prev = r.err;
               end
               results_due.push_back(r);
            end
            ACT_READ_ASSIGN: begin
               r.kind = KIND_ASSIGN;
               r.clu = labels[pos];
               results_due.push_back(r);
            end
            ACT_READ_CENTROID: begin
               r.kind = KIND_CENTROID;
               r.cen = pos < DEF_MAX_CLUSTERS ? centers[pos] : '0;
               results_due.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check(logic [KIND_W-1:0] kind, logic [RSP_DATA_W-1:0] data);
         result_type r;
         if (results_due.size() == 0) begin
            $error("unexpected result item, kind %0d", kind);
            errors++;
            return;
         end
         r = results_due.pop_front();
         if (kind !== r.kind) begin
            $error("result_kind: expected %0d, actual %0d", r.kind, kind);
            errors++;
         end
         if (data[OFS_ITER +: ITER_W] !== r.iters) begin
            $error("iterations: expected %0d, actual %0d", r.iters, data[OFS_ITER +: ITER_W]);
            errors++;
         end
         if (data[OFS_ERR +: ERR_W] !== r.err) begin
            $error("total_error: expected %h, actual %h", r.err, data[OFS_ERR +: ERR_W]);
            errors++;
         end
         if (data[OFS_MONO] !== r.mono) begin
            $error("monotonic: expected %0d, actual %0d", r.mono, data[OFS_MONO]);
            errors++;
         end
         if (data[OFS_CLUSTER +: CLUSTER_W] !== r.clu) begin
            $error("cluster: expected %0d, actual %0d", r.clu, data[OFS_CLUSTER +: CLUSTER_W]);
            errors++;
         end
         if (data[OFS_CENTROID +: VALUE_W] !== r.cen) begin
            $error("centroid: expected %h, actual %h", r.cen, data[OFS_CENTROID +: VALUE_W]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // position, value, zero pad
   logic [ACTION_W-1:0] req_tuser = '0;    // action
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // iterations, total_error, monotonic, cluster, centroid
   logic [KIND_W-1:0] rsp_tuser;           // result_kind
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   kmeans_scoreboard board = new();
   bit point_loaded[DEF_MAX_POINTS];
   bit center_loaded[DEF_MAX_CLUSTERS];
   bit calm = 1'b0;
   int stall_left = 0;
   int items_sent = 0;
   int cycles = 0;

   kmeans_1d_clustering i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: sample at the rising edge, stall a random number of cycles per item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check(rsp_tuser, rsp_tdata);
         stall_left = calm ? 0 : $urandom_range(0, 15);
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && stall_left == 0;
      if (stall_left > 0) stall_left--;
   end

   task automatic send_item(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                            logic [VALUE_W-1:0] val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'd0, val, pos};
      do @(posedge clock); while (!req_tready);
      board.note(act, pos, val);
      if (act == ACT_LOAD_POINT) point_loaded[pos] = 1'b1;
      if (act == ACT_LOAD_CENTROID && pos < DEF_MAX_CLUSTERS) center_loaded[pos] = 1'b1;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.results_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csrs(int n, int k, int m, logic [FRAC_W-1:0] f);
      csr_we <= 1'b1;
      csr_index <= CSR_NUM_POINTS;   csr_wdata <= n;
      @(negedge clock);
      csr_index <= CSR_NUM_CLUSTERS; csr_wdata <= k;
      @(negedge clock);
      csr_index <= CSR_MAX_ITER;     csr_wdata <= m;
      @(negedge clock);
      csr_index <= CSR_FRACTION;     csr_wdata <= f;
      @(negedge clock);
      csr_we <= 1'b0;
      board.n_cfg = NPTS_W'(n);
      board.k_cfg = NCLU_W'(k);
      board.iter_cfg = ITER_W'(m);
      board.frac_cfg = f;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] base);
      if ($urandom_range(0, 3) == 0) return $urandom;
      return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   // loads whatever a run would read that was never written
   task automatic prepare_run(logic [VALUE_W-1:0] base);
      int n, k;
      if (board.iter_cfg == 0) return;
      n = board.clamp_size(board.n_cfg, DEF_MAX_POINTS);
      k = board.clamp_size(board.k_cfg, DEF_MAX_CLUSTERS);
      for (int i = 0; i < n; i++)
         if (!point_loaded[i]) send_item(ACT_LOAD_POINT, POS_W'(i), pick_value(base));
      for (int c = 0; c < k; c++)
         if (!center_loaded[c]) send_item(ACT_LOAD_CENTROID, POS_W'(c), pick_value(base));
   endtask

   task automatic random_phase();
      int n, k, m, spots;
      logic [FRAC_W-1:0] f;
      logic [VALUE_W-1:0] base, centers[4];
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0] pos;
      calm = $urandom_range(0, 5) == 0;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(25, 64) : $urandom_range(1, 24);
      if ($urandom_range(0, 19) == 0) n = $urandom_range(0, 1) ? 0 : $urandom_range(4096, 8191);
      k = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
      m = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (n > 64) m = 0;
      case ($urandom_range(0, 3))
         0: f = '0;
         1: f = $urandom;
         2: f = $urandom_range(1, 1 << 20);
         default: f = '1;
      endcase
      write_csrs(n, k, m, f);
      base = $urandom;
      foreach (centers[j]) centers[j] = base + ($urandom & 32'h00FF_FFFF);
      spots = board.clamp_size(n, 64);
      for (int i = 0; i < spots; i++)
         if ($urandom_range(0, 3) != 0)
            send_item(ACT_LOAD_POINT, POS_W'(i), pick_value(centers[$urandom_range(0, 3)]));
      for (int c = 0; c < board.clamp_size(k, DEF_MAX_CLUSTERS); c++)
         if ($urandom_range(0, 1))
            send_item(ACT_LOAD_CENTROID, POS_W'(c), pick_value(centers[c % 4]));
      for (int j = $urandom_range(0, 4); j > 0; j--) begin
         act = ACTION_W'($urandom_range(0, ACT_LAST));
         pos = POS_W'($urandom_range(0, 4095));
         if (act == ACT_READ_CENTROID && pos < DEF_MAX_CLUSTERS && !center_loaded[pos])
            pos = pos | 12'd16;
         if (act == ACT_LOAD_CENTROID && $urandom_range(0, 1))
            pos = POS_W'(pos % DEF_MAX_CLUSTERS);
         if (act == ACT_RUN) prepare_run(base);
         send_item(act, pos, $urandom);
      end
      for (int r = $urandom_range(1, 2); r > 0; r--) begin
         prepare_run(base);
         send_item(ACT_RUN, POS_W'($urandom), $urandom);
      end
      for (int j = $urandom_range(2, 5); j > 0; j--) begin
         pos = POS_W'($urandom_range(0, 1) ? $urandom_range(0, spots - 1)
                                           : $urandom_range(0, 4095));
         send_item(ACT_READ_ASSIGN, pos, $urandom);
         pos = POS_W'($urandom_range(0, 31));
         if (pos >= DEF_MAX_CLUSTERS || center_loaded[pos])
            send_item(ACT_READ_CENTROID, pos, $urandom);
      end
      drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults from reset: one point, one centroid at opposite extremes
      send_item(ACT_LOAD_POINT, 0, 32'h7FFF_FFFF);
      send_item(ACT_LOAD_CENTROID, 0, 32'h8000_0000);
      send_item(ACT_LOAD_CENTROID, 20, 32'h1234_5678);
      send_item(ACT_LOAD_POINT, 4095, 32'h8000_0000);
      send_item(ACT_RUN, 0, 0);
      send_item(ACT_READ_ASSIGN, 0, 0);
      send_item(ACT_READ_CENTROID, 0, 0);
      send_item(ACT_READ_CENTROID, 4095, 0);
      send_item(ACT_READ_ASSIGN, 4095, 0);
      for (int a = ACT_READ_CENTROID + 1; a <= ACT_LAST; a++)
         send_item(ACTION_W'(a), 0, 32'hFFFF_FFFF);
      drain();

      // equal centroids force ties, a zero fraction never settles
      write_csrs(4, 3, 1023, '0);
      send_item(ACT_LOAD_POINT, 1, 32'h0001_0000);
      send_item(ACT_LOAD_POINT, 2, 32'h8000_0000);
      send_item(ACT_LOAD_POINT, 3, 32'h0000_0000);
      send_item(ACT_LOAD_CENTROID, 1, 32'h8000_0000);
      send_item(ACT_LOAD_CENTROID, 2, 32'h8000_0000);
      send_item(ACT_RUN, 0, 0);
      send_item(ACT_READ_CENTROID, 1, 0);
      send_item(ACT_READ_ASSIGN, 2, 0);
      drain();

      // zero and oversized sizes with no passes, then zero sizes with a pass limit of 3
      write_csrs(0, 0, 0, '1);
      send_item(ACT_RUN, 0, 0);
      drain();
      write_csrs(8191, 31, 0, '1);
      send_item(ACT_RUN, 0, 0);
      drain();
      write_csrs(0, 0, 3, '1);
      send_item(ACT_RUN, 0, 0);
      send_item(ACT_READ_CENTROID, 0, 0);
      drain();

      while (items_sent < ITEM_TARGET) random_phase();

      calm = 1'b0;
      drain();
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
